[hdl/ppfl_pkg.sv]
// Shared types and constants of the per-CPU page free list allocator.
// No dependencies; used by per_cpu_page_free_list.sv.
package ppfl_pkg;

    localparam int CPU_COUNT  = 8;
    localparam int PAGE_COUNT = 32768;
    localparam int PAGE_BYTES = 4096;

    localparam int CPU_W      = $clog2(CPU_COUNT);
    localparam int IDX_W      = $clog2(PAGE_COUNT);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int HEAD_W     = 16;
    localparam int ADDR_W     = 32;
    localparam int SUM_W      = ADDR_W + 2;

    localparam logic [HEAD_W-1:0] LIST_EMPTY = 16'hFFFF;

    localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] REGION_STOP_RST  = 32'h8800_0000;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OOM = 2'd1,
        ST_BAD = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    localparam logic REG_START = 1'b0;
    localparam logic REG_STOP  = 1'b1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_BASE   = 10'b00_0000_0010,
        S_CHKLO  = 10'b00_0000_0100,
        S_CHKHI  = 10'b00_0000_1000,
        S_CHKIDX = 10'b00_0001_0000,
        S_HEAD   = 10'b00_0010_0000,
        S_SCAN   = 10'b00_0100_0000,
        S_POP    = 10'b00_1000_0000,
        S_GRANT  = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

endpackage

[hdl/ppfl_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module ppfl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/per_cpu_page_free_list.sv]
// Top level of the per-CPU page free list allocator.
// Depends on ppfl_pkg and ppfl_ram (next-page link table).
//
// Page allocator with one LIFO free list per CPU. A request names an operation
// (allocate or free) and a CPU; a free also names a page byte address. Each list
// is a head register, and all lists share one link table in RAM that holds the
// next page of every listed page. A free that is misaligned, below region_start,
// at or above region_stop, or beyond the managed page count is refused with a
// bad-free status and leaves the lists alone; a good free pushes the page onto
// the CPU's list. An allocate pops the CPU's own list, or else steals the head
// page of the lowest-numbered other CPU with a non-empty list, or reports out of
// memory with address 0. All lists are empty after reset; software frees the
// pages it wants managed. One request is worked on at a time under a small
// sequencer that drives a single shared 34-bit add/subtract unit: it rounds up
// the page base, performs the three range checks of a free one after another,
// and rebuilds the granted address. An allocate that finds its own list empty
// steals after a scan of the head registers, one head register per cycle,
// lowest first; the pop waits on the link-table read. The result sits in an
// output register, so a new request is taken while it waits. A full result
// register holds the sequencer in its last step until the transfer on the
// master side completes.
//
// s_tdata  : [2:0] cpu, [34:3] page_address, [39:35] zero
// s_tuser  : [0] operation
// m_tdata  : [31:0] granted_address, [32] stolen, [39:33] zero
// m_tuser  : [1:0] status
// Registers: 0x0 region_start, 0x4 region_stop.
module per_cpu_page_free_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] cpu, [34:3] page_address
    input  logic [0:0]  s_tuser,   // [0] operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] granted_address, [32] stolen
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int CPU_W  = ppfl_pkg::CPU_W;
    localparam int IDX_W  = ppfl_pkg::IDX_W;
    localparam int SHIFT  = ppfl_pkg::PAGE_SHIFT;
    localparam int HEAD_W = ppfl_pkg::HEAD_W;
    localparam int ADDR_W = ppfl_pkg::ADDR_W;
    localparam int SUM_W  = ppfl_pkg::SUM_W;
    localparam int NCPU   = ppfl_pkg::CPU_COUNT;

    // Sequencer and request registers
    ppfl_pkg::t_state     r_state, n_state;
    logic                 r_op, n_op;
    logic [CPU_W-1:0]     r_cpu, n_cpu;
    logic [CPU_W-1:0]     r_sel, n_sel;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [ADDR_W:0]      r_base, n_base;
    logic                 r_bad, n_bad;
    logic [HEAD_W-1:0]    r_page, n_page;
    logic                 r_stolen, n_stolen;
    logic [1:0]           r_status, n_status;
    logic [ADDR_W-1:0]    r_grant, n_grant;

    // List heads and configuration
    logic [HEAD_W-1:0]    r_head [NCPU];
    logic [HEAD_W-1:0]    n_head [NCPU];
    logic [ADDR_W-1:0]    r_start, n_start;
    logic [ADDR_W-1:0]    r_stop, n_stop;

    // Output register
    logic                 r_m_valid, n_m_valid;
    logic [1:0]           r_m_status, n_m_status;
    logic [ADDR_W-1:0]    r_m_grant, n_m_grant;
    logic                 r_m_stolen, n_m_stolen;

    // Shared add/subtract unit
    logic [SUM_W-1:0]     w_add_a, w_add_b, w_sum;
    logic                 w_sub;

    logic [HEAD_W-1:0]    w_head;
    logic                 w_head_ok;
    logic                 w_cfg_we;
    logic                 w_ram_we, w_ram_re;
    logic [IDX_W-1:0]     w_ram_waddr, w_ram_raddr;
    logic [HEAD_W-1:0]    w_ram_rdata;

    assign w_sum = w_add_a + (w_sub ? ~w_add_b : w_add_b) + SUM_W'(w_sub);

    assign w_head    = r_head[r_sel];
    assign w_head_ok = (w_head < HEAD_W'(ppfl_pkg::PAGE_COUNT));

    assign w_cfg_we = psel & penable & pwrite & pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ppfl_pkg::REG_STOP) ? r_stop : r_start;

    assign s_tready = (r_state == ppfl_pkg::S_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = {7'd0, r_m_stolen, r_m_grant};
    assign m_tuser  = r_m_status;

    ppfl_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (ppfl_pkg::PAGE_COUNT)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_head),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_cpu      = r_cpu;
        n_sel      = r_sel;
        n_addr     = r_addr;
        n_base     = r_base;
        n_bad      = r_bad;
        n_page     = r_page;
        n_stolen   = r_stolen;
        n_status   = r_status;
        n_grant    = r_grant;
        n_head     = r_head;
        n_start    = r_start;
        n_stop     = r_stop;
        n_m_valid  = r_m_valid;
        n_m_status = r_m_status;
        n_m_grant  = r_m_grant;
        n_m_stolen = r_m_stolen;

        w_add_a     = {2'b00, r_addr};
        w_add_b     = {2'b00, r_start};
        w_sub       = 1'b1;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_waddr = w_sum[SHIFT +: IDX_W];
        w_ram_raddr = w_head[IDX_W-1:0];

        // Configuration writes
        if (w_cfg_we) begin
            if (paddr[2] == ppfl_pkg::REG_STOP) begin
                n_stop = pwdata;
            end else begin
                n_start = pwdata;
            end
        end

        // Drop the result once the master side takes it
        if (r_m_valid && m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ppfl_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    // The cpu field spans exactly CPU_COUNT values, so it wraps by itself
                    n_op     = s_tuser[0];
                    n_cpu    = s_tdata[CPU_W-1:0];
                    n_sel    = s_tdata[CPU_W-1:0];
                    n_addr   = s_tdata[34:3];
                    n_bad    = 1'b0;
                    n_stolen = 1'b0;
                    n_grant  = '0;
                    n_state  = ppfl_pkg::S_BASE;
                end
            end
            ppfl_pkg::S_BASE: begin
                // Round region_start up to a page boundary
                w_add_a = {2'b00, r_start};
                w_add_b = SUM_W'(ppfl_pkg::PAGE_BYTES - 1);
                w_sub   = 1'b0;
                n_base  = {w_sum[ADDR_W:SHIFT], SHIFT'(0)};
                n_state = (r_op == ppfl_pkg::OP_FREE) ? ppfl_pkg::S_CHKLO
                                                      : ppfl_pkg::S_HEAD;
            end
            ppfl_pkg::S_CHKLO: begin
                // Misaligned or below region_start
                n_bad   = (r_addr[SHIFT-1:0] != '0) | w_sum[SUM_W-1];
                n_state = ppfl_pkg::S_CHKHI;
            end
            ppfl_pkg::S_CHKHI: begin
                // At or above region_stop
                w_add_b = {2'b00, r_stop};
                n_bad   = r_bad | ~w_sum[SUM_W-1];
                n_state = ppfl_pkg::S_CHKIDX;
            end
            ppfl_pkg::S_CHKIDX: begin
                // Below the rounded base or beyond the last page
                w_add_b = {1'b0, r_base};
                if (r_bad || w_sum[SUM_W-1] ||
                    (w_sum[SUM_W-1:SHIFT] >= (SUM_W-SHIFT)'(ppfl_pkg::PAGE_COUNT))) begin
                    n_status = ppfl_pkg::ST_BAD;
                end else begin
                    w_ram_we      = 1'b1;
                    n_head[r_sel] = HEAD_W'(w_sum[SHIFT +: IDX_W]);
                    n_status      = ppfl_pkg::ST_OK;
                end
                n_state = ppfl_pkg::S_DONE;
            end
            ppfl_pkg::S_HEAD: begin
                if (w_head_ok) begin
                    w_ram_re = 1'b1;
                    n_page   = w_head;
                    n_state  = ppfl_pkg::S_POP;
                end else begin
                    n_sel   = '0;
                    n_state = ppfl_pkg::S_SCAN;
                end
            end
            ppfl_pkg::S_SCAN: begin
                // Advance one CPU a cycle, lowest first, skipping the requester
                if ((r_sel != r_cpu) && w_head_ok) begin
                    w_ram_re = 1'b1;
                    n_page   = w_head;
                    n_stolen = 1'b1;
                    n_state  = ppfl_pkg::S_POP;
                end else if (r_sel == CPU_W'(NCPU - 1)) begin
                    n_status = ppfl_pkg::ST_OOM;
                    n_state  = ppfl_pkg::S_DONE;
                end else begin
                    n_sel = r_sel + CPU_W'(1);
                end
            end
            ppfl_pkg::S_POP: begin
                n_head[r_sel] = w_ram_rdata;
                n_state       = ppfl_pkg::S_GRANT;
            end
            ppfl_pkg::S_GRANT: begin
                w_add_a  = {1'b0, r_base};
                w_add_b  = {(SUM_W-IDX_W-SHIFT)'(0), r_page[IDX_W-1:0], SHIFT'(0)};
                w_sub    = 1'b0;
                n_grant  = w_sum[ADDR_W-1:0];
                n_status = ppfl_pkg::ST_OK;
                n_state  = ppfl_pkg::S_DONE;
            end
            ppfl_pkg::S_DONE: begin
                // Hold until the output register is free
                if (!r_m_valid || m_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_grant  = r_grant;
                    n_m_stolen = r_stolen;
                    n_state    = ppfl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppfl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ppfl_pkg::S_IDLE;
            r_m_valid <= 1'b0;
            r_start   <= ppfl_pkg::REGION_START_RST;
            r_stop    <= ppfl_pkg::REGION_STOP_RST;
            for (int i = 0; i < NCPU; i++) begin
                r_head[i] <= ppfl_pkg::LIST_EMPTY;
            end
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_start   <= n_start;
            r_stop    <= n_stop;
            r_head    <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_cpu      <= n_cpu;
        r_sel      <= n_sel;
        r_addr     <= n_addr;
        r_base     <= n_base;
        r_bad      <= n_bad;
        r_page     <= n_page;
        r_stolen   <= n_stolen;
        r_status   <= n_status;
        r_grant    <= n_grant;
        r_m_status <= n_m_status;
        r_m_grant  <= n_m_grant;
        r_m_stolen <= n_m_stolen;
    end

endmodule

[bench/per_cpu_page_free_list_tb.sv]
// Testbench for the per-CPU page free list allocator: a directed burst, then random
// request streams under several region settings, checked against a predictor.
// Depends on ppfl_pkg and per_cpu_page_free_list.
module per_cpu_page_free_list_tb;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int HOLD_CYCLES    = 300;   // one long result-side hold-off
    localparam int MAX_REPORTS    = 10;
    localparam int GAP_PCT        = 18;

    typedef struct packed {
        ppfl_pkg::t_op op;
        logic [2:0]    cpu;
        logic [31:0]   addr;
    } t_request;

    typedef struct packed {
        ppfl_pkg::t_status status;
        logic [31:0]       granted;
        logic              stolen;
    } t_grant;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    always #5 i_clk = ~i_clk;

    per_cpu_page_free_list dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [2:0] cpu, [34:3] page_address, [39:35] zero
        .s_tuser  (s_tuser),   // [0] operation
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] granted_address, [32] stolen, [39:33] zero
        .m_tuser  (m_tuser)    // [1:0] status
    );

    // ------------------------------------------------------------------
    // Predictor state: region registers, list heads and the link table
    // ------------------------------------------------------------------
    logic [31:0]                 cfg_start = ppfl_pkg::REGION_START_RST;
    logic [31:0]                 cfg_stop  = ppfl_pkg::REGION_STOP_RST;
    logic [ppfl_pkg::HEAD_W-1:0] head_of [ppfl_pkg::CPU_COUNT];
    logic [ppfl_pkg::HEAD_W-1:0] link_of [ppfl_pkg::PAGE_COUNT];

    t_request requests_pending[$];
    t_grant   grants_due[$];
    logic     item_loaded = 1'b0;  // driver holds an offered request
    logic     no_gaps     = 1'b0;  // both sides run flat out
    logic     hold_go     = 1'b0;
    logic     holding     = 1'b0;
    int       hold_count  = 0;
    int       idle_cycles = 0;
    int       mismatches  = 0;

    initial begin
        foreach (head_of[i]) head_of[i] = ppfl_pkg::LIST_EMPTY;
    end

    // Page base: region_start rounded up to a whole page, kept wide so it may pass 2^32.
    function automatic logic [33:0] region_base();
        return ({2'b0, cfg_start} + 34'(ppfl_pkg::PAGE_BYTES - 1)) &
               ~34'(ppfl_pkg::PAGE_BYTES - 1);
    endfunction

    // Work out the result of one request and advance the list state.
    function automatic t_grant serve_request(ppfl_pkg::t_op op, logic [2:0] cpu,
                                             logic [31:0] addr);
        logic [33:0]                 base;
        logic [33:0]                 idx;
        logic [ppfl_pkg::HEAD_W-1:0] page;
        int                          c;
        int                          owner;
        t_grant                      g;
        base      = region_base();
        c         = int'(cpu) % ppfl_pkg::CPU_COUNT;
        owner     = -1;
        g.status  = ppfl_pkg::ST_OK;
        g.granted = '0;
        g.stolen  = 1'b0;
        if (op == ppfl_pkg::OP_FREE) begin
            idx = ({2'b0, addr} - base) >> ppfl_pkg::PAGE_SHIFT;
            if (addr[ppfl_pkg::PAGE_SHIFT-1:0] != '0 || addr < cfg_start ||
                addr >= cfg_stop || {2'b0, addr} < base ||
                idx >= ppfl_pkg::PAGE_COUNT) begin
                g.status = ppfl_pkg::ST_BAD;
            end else begin
                link_of[idx[ppfl_pkg::IDX_W-1:0]] = head_of[c];
                head_of[c] = idx[ppfl_pkg::HEAD_W-1:0];
            end
            return g;
        end
        // own list first, else the lowest-numbered other CPU holding a page
        if (head_of[c] < ppfl_pkg::PAGE_COUNT) begin
            owner = c;
        end else begin
            for (int k = 0; k < ppfl_pkg::CPU_COUNT; k++) begin
                if (owner < 0 && k != c && head_of[k] < ppfl_pkg::PAGE_COUNT) owner = k;
            end
        end
        if (owner < 0) begin
            g.status = ppfl_pkg::ST_OOM;
            return g;
        end
        page = head_of[owner];
        head_of[owner] = link_of[page[ppfl_pkg::IDX_W-1:0]];
        g.granted = 32'(base + (34'(page) << ppfl_pkg::PAGE_SHIFT));
        g.stolen  = (owner != c);
        return g;
    endfunction

    task automatic note_mismatch(string what);
        if (mismatches < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: predict on each transfer, then load the next request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            item_loaded = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                grants_due.push_back(serve_request(ppfl_pkg::t_op'(s_tuser[0]),
                                                   s_tdata[2:0], s_tdata[34:3]));
                item_loaded = 1'b0;
            end
            if (!item_loaded && requests_pending.size() != 0 &&
                (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
                nxt = requests_pending.pop_front();
                s_tdata  <= {5'b0, nxt.addr, nxt.cpu};
                s_tuser  <= nxt.op;
                s_tvalid <= 1'b1;
                item_loaded = 1'b1;
            end else if (!item_loaded) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long hold-off of the result side, counted here once started
    always @(posedge i_clk) begin
        if (hold_go && hold_count < HOLD_CYCLES) begin
            holding    <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            holding <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) m_tready <= 1'b0;
        else m_tready <= !holding && (no_gaps || $urandom_range(99) >= GAP_PCT);
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (grants_due.size() == 0) begin
                note_mismatch($sformatf("result with nothing expected: status %0d addr %h",
                                        m_tuser, m_tdata[31:0]));
            end else begin
                want = grants_due.pop_front();
                if (m_tuser !== want.status)
                    note_mismatch($sformatf("status exp %0d got %0d", want.status, m_tuser));
                if (m_tdata[31:0] !== want.granted)
                    note_mismatch($sformatf("granted_address exp %h got %h",
                                            want.granted, m_tdata[31:0]));
                if (m_tdata[32] !== want.stolen)
                    note_mismatch($sformatf("stolen exp %0b got %0b", want.stolen, m_tdata[32]));
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("per_cpu_page_free_list_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_request(ppfl_pkg::t_op op, int cpu, logic [31:0] addr);
        requests_pending.push_back('{op, 3'(cpu), addr});
    endtask

    // Aligned address inside the current region, or noise when none exists
    function automatic logic [31:0] good_page_addr();
        logic [33:0] lo;
        logic [33:0] hi;
        lo = region_base();
        hi = {2'b0, cfg_stop};
        if (hi > lo + (34'(ppfl_pkg::PAGE_COUNT) << ppfl_pkg::PAGE_SHIFT))
            hi = lo + (34'(ppfl_pkg::PAGE_COUNT) << ppfl_pkg::PAGE_SHIFT);
        if (hi <= lo) return $urandom();
        return 32'(lo + (34'($urandom_range(int'((hi - lo - 1) >> ppfl_pkg::PAGE_SHIFT)))
                         << ppfl_pkg::PAGE_SHIFT));
    endfunction

    function automatic logic [31:0] bad_page_addr();
        case ($urandom_range(3))
            0: return good_page_addr() | 32'($urandom_range(1, ppfl_pkg::PAGE_BYTES - 1));
            1: return 32'(region_base() - (34'($urandom_range(1, 4)) << ppfl_pkg::PAGE_SHIFT));
            2: return 32'((({2'b0, cfg_stop} + 34'(ppfl_pkg::PAGE_BYTES - 1)) &
                           ~34'(ppfl_pkg::PAGE_BYTES - 1)) +
                          (34'($urandom_range(3)) << ppfl_pkg::PAGE_SHIFT));
            default: return $urandom();
        endcase
    endfunction

    // Bursts of twenty with a varying allocate share; reuse_pct sets how often an
    // address freed earlier in the run is freed again.
    task automatic run_random(int count, int reuse_pct);
        logic [31:0] freed[$];
        logic [31:0] a;
        int          alloc_pct;
        int          roll;
        alloc_pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 20 == 0) alloc_pct = 25 + 25 * $urandom_range(2);
            roll = $urandom_range(99);
            if (roll < alloc_pct) begin
                queue_request(ppfl_pkg::OP_ALLOC, $urandom_range(7), $urandom());
            end else begin
                roll = $urandom_range(99);
                if (roll < 10) begin
                    a = bad_page_addr();
                end else if (roll < 10 + reuse_pct && freed.size() != 0) begin
                    a = freed[$urandom_range(freed.size() - 1)];
                end else begin
                    a = good_page_addr();
                    freed.push_back(a);
                end
                queue_request(ppfl_pkg::OP_FREE, $urandom_range(7), a);
            end
        end
    endtask

    task automatic wait_drained();
        while (requests_pending.size() != 0 || item_loaded || grants_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic write_region(logic reg_sel, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == ppfl_pkg::REG_START) cfg_start = value;
        else cfg_stop = value;
    endtask

    task automatic set_region(logic [31:0] start_addr, logic [31:0] stop_addr);
        wait_drained();
        write_region(ppfl_pkg::REG_START, start_addr);
        write_region(ppfl_pkg::REG_STOP, stop_addr);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed burst on the reset region: empty lists, region edges, bad frees,
        // own pop, steal, a page freed onto two lists, lowest-numbered steal.
        queue_request(ppfl_pkg::OP_ALLOC, 0, $urandom());
        queue_request(ppfl_pkg::OP_FREE,  0, 32'h8000_0000);
        queue_request(ppfl_pkg::OP_FREE,  7, 32'h87FF_F000);
        queue_request(ppfl_pkg::OP_FREE,  1, 32'h7FFF_F000);
        queue_request(ppfl_pkg::OP_FREE,  1, 32'h8800_0000);
        queue_request(ppfl_pkg::OP_FREE,  1, 32'h8000_0800);
        queue_request(ppfl_pkg::OP_FREE,  1, 32'h8000_0001);
        queue_request(ppfl_pkg::OP_FREE,  1, 32'hFFFF_FFFF);
        queue_request(ppfl_pkg::OP_FREE,  1, 32'h0000_0000);
        queue_request(ppfl_pkg::OP_ALLOC, 0, $urandom());
        queue_request(ppfl_pkg::OP_ALLOC, 0, $urandom());
        queue_request(ppfl_pkg::OP_ALLOC, 3, $urandom());
        queue_request(ppfl_pkg::OP_FREE,  1, 32'h8000_5000);
        queue_request(ppfl_pkg::OP_FREE,  2, 32'h8000_5000);
        queue_request(ppfl_pkg::OP_ALLOC, 1, $urandom());
        queue_request(ppfl_pkg::OP_ALLOC, 2, $urandom());
        queue_request(ppfl_pkg::OP_ALLOC, 2, $urandom());
        queue_request(ppfl_pkg::OP_FREE,  5, 32'h8123_4000);
        queue_request(ppfl_pkg::OP_FREE,  6, 32'h8765_4000);
        queue_request(ppfl_pkg::OP_FREE,  5, 32'h8000_1000);
        queue_request(ppfl_pkg::OP_ALLOC, 0, $urandom());
        queue_request(ppfl_pkg::OP_ALLOC, 5, $urandom());
        queue_request(ppfl_pkg::OP_ALLOC, 6, $urandom());
        queue_request(ppfl_pkg::OP_ALLOC, 4, $urandom());

        // Reset region written back explicitly; no gaps on either side here
        set_region(ppfl_pkg::REGION_START_RST, ppfl_pkg::REGION_STOP_RST);
        no_gaps = 1'b1;
        run_random(250, 2);
        wait_drained();
        no_gaps = 1'b0;

        // Widest region; hold results back so the block fills and stalls requests
        set_region(32'h0000_0000, 32'hFFFF_FFFF);
        run_random(200, 2);
        hold_go = 1'b1;

        // Unaligned start: base rounds up to the next page
        set_region(32'h1234_5678, 32'h1300_0000);
        run_random(200, 2);

        // Base beyond 32 bits: every free refused, grants wrap
        set_region(32'hFFFF_F001, 32'hFFFF_FFFF);
        run_random(60, 0);

        // Only the top page of the address space is valid
        set_region(32'hFFFF_F000, 32'hFFFF_FFFF);
        run_random(60, 5);

        // Small region: frequent steals, out of memory and double frees
        set_region(32'h4000_0000, 32'h4010_0000);
        run_random(150, 15);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("per_cpu_page_free_list_tb passed");
        end else begin
            $display("per_cpu_page_free_list_tb failed");
        end
        $finish;
    end

endmodule
